// File: hw/rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// Shared constants, types and helpers of the top-k smallest selector.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int MAX_K    = 32;
  localparam int ID_WIDTH = 16;
  localparam int DIST_W   = 8;
  localparam int KC_W     = 6;
  localparam int FUNC_W   = 2;
  localparam int CNT_W    = $clog2(MAX_K + 1);
  localparam int IDX_W    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int ENTRY_W  = ID_WIDTH + DIST_W;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [KC_W-1:0]   KEEP_RESET = KC_W'(10);
  localparam logic [DIST_W-1:0] THR_RESET  = DIST_W'(255);

  // func codes; the fourth code is unused and only gives a status word
  localparam logic [FUNC_W-1:0] FN_OFFER = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

  // register indexes (word address paddr[2])
  localparam logic REG_KEEP = 1'b0;
  localparam logic REG_THR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [KC_W-1:0]   keep_count;
    logic [DIST_W-1:0] initial_threshold;
  } cfg_t;

  // ordering key: distance first, then id, then slot index to split duplicates
  typedef struct packed {
    logic [DIST_W-1:0]   dval;
    logic [ID_WIDTH-1:0] id;
    logic [IDX_W-1:0]    idx;
  } key_t;

  typedef struct packed {
    logic clr;
    logic find_max;
    logic have_prev;
  } scan_ctrl_t;

  function automatic logic [CNT_W-1:0] sat_keep(input logic [KC_W-1:0] kc);
    logic [CNT_W-1:0] k;
    if (int'(kc) > MAX_K) k = CNT_W'(MAX_K);
    else k = CNT_W'(kc);
    return k;
  endfunction

endpackage

// File: hw/rtl/tks_ram.sv
// ----------------------------------------------------------------------------
// tks_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/tks_regs.sv
// ----------------------------------------------------------------------------
// tks_regs
// APB-style register file: keep count and initial threshold.
// ----------------------------------------------------------------------------
module tks_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tks_pkg::ADDR_W-1:0]  paddr,
  input  logic [tks_pkg::DATA_W-1:0]  pwdata,
  output logic [tks_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tks_pkg::cfg_t               cfg
);
  import tks_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keep_count        <= KEEP_RESET;
      cfg.initial_threshold <= THR_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_KEEP: cfg.keep_count        <= pwdata[KC_W-1:0];
        REG_THR:  cfg.initial_threshold <= pwdata[DIST_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_KEEP: prdata = DATA_W'(cfg.keep_count);
      REG_THR:  prdata = DATA_W'(cfg.initial_threshold);
      default:  prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/tks_scan.sv
// ----------------------------------------------------------------------------
// tks_scan
// Running search over words streamed from the entry RAM: either the largest
// key, or the smallest key (above the one emitted last, once one has been).
// ----------------------------------------------------------------------------
module tks_scan (
  input  logic                clk,
  input  logic                rst,
  input  tks_pkg::scan_ctrl_t ctrl,
  input  logic                sample_valid,
  input  tks_pkg::key_t       sample,
  input  tks_pkg::key_t       prev,
  output tks_pkg::key_t       best
);
  import tks_pkg::*;

  logic found;
  logic take;

  always_comb begin
    if (ctrl.find_max) begin
      take = sample_valid && (!found || (sample > best));
    end else begin
      take = sample_valid && (!ctrl.have_prev || (sample > prev))
                          && (!found || (sample < best));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best <= sample;
    end
  end

endmodule

// File: hw/rtl/top_k_smallest_selector_unit.sv
// ----------------------------------------------------------------------------
// top_k_smallest_selector_unit
// Keeps the k smallest-distance (distance, id) pairs of one query.
// ----------------------------------------------------------------------------
// Entries sit in a 32-word RAM with one read and one write port; all work
// goes through that single read port, one word per cycle. A clear, a rejected
// offer with k zero, an offer into a store not yet full or an unused func
// loads its result word in the EXEC state once the output register is free,
// and the unit then returns to idle. An offer into a full store sweeps the n
// held entries for the largest pair through the SCAN and DRAIN states: its
// word is loaded in FINISH. A read-out runs one sweep per emitted word,
// loading each word in FINISH; an empty store gives its single word from
// EXEC. A stalled output holds the unit in EXEC or FINISH. One item is worked
// on at a time; the next is taken as soon as the last result word sits in the
// output register. The RAM is never cleared: only entries below the held
// count are read.
// ----------------------------------------------------------------------------
module top_k_smallest_selector_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tks_pkg::ADDR_W-1:0]    paddr,
  input  logic [tks_pkg::DATA_W-1:0]    pwdata,
  output logic [tks_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tks_pkg::FUNC_W-1:0]    func,
  input  logic [tks_pkg::ID_WIDTH-1:0]  item_id,
  input  logic [tks_pkg::DIST_W-1:0]    dist_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          accepted,
  output logic [tks_pkg::DIST_W-1:0]    current_threshold,
  output logic [tks_pkg::CNT_W-1:0]     held_count,
  output logic [tks_pkg::ID_WIDTH-1:0]  out_id,
  output logic [tks_pkg::DIST_W-1:0]    out_dist,
  output logic                          last
);
  import tks_pkg::*;

  cfg_t cfg;
  state_t state, state_next;

  logic [FUNC_W-1:0]   func_q;
  logic [ID_WIDTH-1:0] id_q;
  logic [DIST_W-1:0]   dist_q;

  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [DIST_W-1:0] thr, thr_next;
  logic [IDX_W-1:0]  rd_idx, rd_tag;
  logic              rd_vld;
  logic [CNT_W-1:0]  emitted;
  logic              have_prev;
  key_t              prev, best, sample;

  logic [ENTRY_W-1:0] mem_rdata, mem_wdata;
  logic [IDX_W-1:0]   mem_waddr;
  logic               mem_we;

  logic [CNT_W-1:0] k_eff;
  logic             in_fire, out_free, is_full, offer_scan, read_scan;
  logic             last_rd, readout_done;
  logic             rd_issue, load_res, adv_read, scan_clr, cnt_we, thr_we;
  scan_ctrl_t       scan_ctrl;

  logic              res_acc, res_last;
  logic [DIST_W-1:0] res_thr, res_dist;
  logic [CNT_W-1:0]  res_cnt;
  logic [ID_WIDTH-1:0] res_id;

  tks_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tks_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_K)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx),
    .rdata (mem_rdata)
  );

  assign sample = '{dval: mem_rdata[DIST_W-1:0],
                    id:   mem_rdata[ENTRY_W-1:DIST_W],
                    idx:  rd_tag};

  assign scan_ctrl = '{clr: scan_clr, find_max: (func_q == FN_OFFER),
                       have_prev: have_prev};

  tks_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (scan_ctrl),
    .sample_valid (rd_vld),
    .sample       (sample),
    .prev         (prev),
    .best         (best)
  );

  assign k_eff        = sat_keep(cfg.keep_count);
  assign in_ready     = (state == ST_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign out_free     = !out_valid || out_ready;
  assign is_full      = (entry_count >= k_eff);
  assign offer_scan   = (func_q == FN_OFFER) && (k_eff != '0) && is_full;
  assign read_scan    = (func_q == FN_READ) && (entry_count != '0);
  assign last_rd      = (CNT_W'(rd_idx) == entry_count - CNT_W'(1));
  assign readout_done = (emitted + CNT_W'(1) == entry_count);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (offer_scan || read_scan) state_next = ST_SCAN;
        else if (out_free) state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (last_rd) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          if ((func_q == FN_READ) && !readout_done) state_next = ST_SCAN;
          else state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath control and result word
  always_comb begin
    rd_issue         = 1'b0;
    load_res         = 1'b0;
    adv_read         = 1'b0;
    scan_clr         = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = entry_count[IDX_W-1:0];
    mem_wdata        = {id_q, dist_q};
    cnt_we           = 1'b0;
    thr_we           = 1'b0;
    entry_count_next = entry_count;
    thr_next         = thr;
    res_acc          = 1'b0;
    res_thr          = thr;
    res_cnt          = entry_count;
    res_id           = '0;
    res_dist         = '0;
    res_last         = 1'b1;
    unique case (state)
      ST_EXEC: begin
        if (offer_scan || read_scan) begin
          scan_clr = 1'b1;
        end else if (out_free) begin
          load_res = 1'b1;
          if ((func_q == FN_OFFER) && (k_eff != '0)) begin
            // store not full: append at the count
            mem_we           = 1'b1;
            cnt_we           = 1'b1;
            entry_count_next = entry_count + CNT_W'(1);
            res_acc          = 1'b1;
            res_cnt          = entry_count_next;
          end else if (func_q == FN_CLEAR) begin
            cnt_we           = 1'b1;
            thr_we           = 1'b1;
            entry_count_next = '0;
            thr_next         = cfg.initial_threshold;
            res_cnt          = '0;
            res_thr          = cfg.initial_threshold;
          end
        end
      end
      ST_SCAN: rd_issue = 1'b1;
      ST_FINISH: begin
        if (out_free) begin
          load_res = 1'b1;
          scan_clr = 1'b1;
          if (func_q == FN_OFFER) begin
            // replace the largest pair only on a strictly smaller distance
            if (best.dval > dist_q) begin
              mem_we    = 1'b1;
              mem_waddr = best.idx;
              thr_we    = 1'b1;
              thr_next  = dist_q;
              res_acc   = 1'b1;
              res_thr   = dist_q;
            end
          end else begin
            adv_read = 1'b1;
            res_id   = best.id;
            res_dist = best.dval;
            res_last = readout_done;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      thr         <= THR_RESET;
      rd_idx      <= '0;
      rd_vld      <= 1'b0;
      have_prev   <= 1'b0;
      emitted     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_issue;
      rd_idx <= rd_issue ? rd_idx + IDX_W'(1) : '0;
      if (cnt_we) entry_count <= entry_count_next;
      if (thr_we) thr <= thr_next;
      if (in_fire) begin
        have_prev <= 1'b0;
        emitted   <= '0;
      end else if (adv_read) begin
        have_prev <= 1'b1;
        emitted   <= emitted + CNT_W'(1);
      end
      if (load_res) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload: hold the item, the read tag, the last emitted key and the word
  always_ff @(posedge clk) begin
    rd_tag <= rd_idx;
    if (in_fire) begin
      func_q <= func;
      id_q   <= item_id;
      dist_q <= dist_req;
    end
    if (adv_read) prev <= best;
    if (load_res) begin
      accepted          <= res_acc;
      current_threshold <= res_thr;
      held_count        <= res_cnt;
      out_id            <= res_id;
      out_dist          <= res_dist;
      last              <= res_last;
    end
  end

endmodule
